>>> rtl/core/chaskey_pkg.sv
package chaskey_pkg;

    localparam int BLOCK_W   = 128;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] MAC_POLY    = 8'h87;
    localparam logic [7:0] PAD_BYTE    = 8'h01;
    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd2;

    // microprogram step addresses
    typedef logic [1:0] step_t;
    localparam step_t STEP_IDLE   = 2'd0;
    localparam step_t STEP_ABSORB = 2'd1;
    localparam step_t STEP_ROUND  = 2'd2;
    localparam step_t STEP_FINISH = 2'd3;

    // jump condition: taken -> target, otherwise fall through to the next step
    typedef enum logic [1:0] {
        COND_NO_INPUT,
        COND_ZERO_ROUNDS,
        COND_MORE_ROUNDS,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  absorb;
        logic  arx;
        logic  finish;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = '{take_in: 1'b0, absorb: 1'b0, arx: 1'b0, finish: 1'b0,
              cond: COND_NO_INPUT, target: STEP_IDLE};
        unique case (s)
            STEP_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = COND_NO_INPUT;
                w.target  = STEP_IDLE;
            end
            STEP_ABSORB:
            begin
                w.absorb = 1'b1;
                w.cond   = COND_ZERO_ROUNDS;
                w.target = STEP_FINISH;
            end
            STEP_ROUND:
            begin
                w.arx    = 1'b1;
                w.cond   = COND_MORE_ROUNDS;
                w.target = STEP_ROUND;
            end
            STEP_FINISH:
            begin
                w.finish = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_FINISH;
            end
        endcase
        return w;
    endfunction

    // doubling in GF(2^128)
    function automatic logic [BLOCK_W-1:0] dbl(input logic [BLOCK_W-1:0] k);
        return {k[BLOCK_W-2:0], 1'b0}
             ^ {{(BLOCK_W-8){1'b0}}, (k[BLOCK_W-1] ? MAC_POLY : 8'h00)};
    endfunction

endpackage

>>> rtl/core/chaskey_arx.sv
module chaskey_arx
    import chaskey_pkg::*;
(
    input  logic [BLOCK_W-1:0] v_in,
    output logic [BLOCK_W-1:0] v_out
);

    logic [31:0] a0, a1, a2, a3;
    logic [31:0] b0, b1, b2, b3;
    logic [31:0] c0, c3;
    logic [31:0] d1, d2;

    always_comb
    begin
        a0 = v_in[31:0] + v_in[63:32];
        a1 = {v_in[58:32], v_in[63:59]} ^ a0;
        b0 = {a0[15:0], a0[31:16]};
        a2 = v_in[95:64] + v_in[127:96];
        a3 = {v_in[119:96], v_in[127:120]} ^ a2;
        c0 = b0 + a3;
        b3 = {a3[18:0], a3[31:19]} ^ c0;
        b2 = a2 + a1;
        b1 = {a1[24:0], a1[31:25]} ^ b2;
        d2 = {b2[15:0], b2[31:16]};
        d1 = b1;
        c3 = b3;
        v_out = {c3, d2, d1, c0};
    end

endmodule

>>> rtl/core/chaskey_mac_engine.sv
// Chaskey MAC engine, microcoded: idle, absorb, R rounds, finish.
// The tag reaches m_tvalid after the absorb step, the R rounds and the finish step,
// R = round_count; one ARX round per cycle through the single round unit.
// A new block is taken only in the idle step, once the previous block is done;
// the finish step of a final block stalls while a previous tag is still waiting.
// Reset: rst_n asynchronous, active low; key 0, round count 8, no message open.
module chaskey_mac_engine
    import chaskey_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BLOCK_W-1:0]   s_tdata,   // block_word0, block_word1, block_word2, block_word3
    input  logic                 s_tlast,
    input  logic [4:0]           s_tuser,   // valid_bytes
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BLOCK_W-1:0]   m_tdata,   // tag_low, tag_high
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0]        key_low_reg, key_high_reg;
    logic [7:0]         rounds_reg;
    step_t              pc_reg, pc_next;
    logic [7:0]         cnt_reg;
    logic               open_reg;
    logic               final_reg;
    logic               full_reg;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic [BLOCK_W-1:0] chain_reg;
    logic [BLOCK_W-1:0] tag_reg;
    logic               out_valid_reg;

    ctrl_t              ctrl;
    logic               s_accept;
    logic               out_busy;
    logic               cond_hit;
    logic [BLOCK_W-1:0] key;
    logic [BLOCK_W-1:0] k1;
    logic [BLOCK_W-1:0] lk;
    logic [BLOCK_W-1:0] arx_out;
    logic [4:0]         nsat;

    assign ctrl      = ucode(pc_reg);
    assign s_tready  = ctrl.take_in;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = tag_reg;
    assign out_busy  = final_reg && out_valid_reg && !m_tready;

    assign key = {key_high_reg, key_low_reg};
    assign k1  = dbl(key);
    assign lk  = full_reg ? k1 : dbl(k1);

    chaskey_arx u_arx
    (
        .v_in  (chain_reg),
        .v_out (arx_out)
    );

    // zero the bytes past the count and place the pad byte (short final block)
    always_comb
    begin
        nsat     = (s_tuser > BLOCK_BYTES) ? BLOCK_BYTES : s_tuser;
        blk_next = s_tdata;
        if (s_tlast && nsat != BLOCK_BYTES)
        begin
            for (int j = 0; j < BLOCK_W / 8; j++)
            begin
                if (5'(j) == nsat)
                    blk_next[8*j +: 8] = PAD_BYTE;
                else if (5'(j) > nsat)
                    blk_next[8*j +: 8] = 8'h00;
            end
        end
    end

    always_comb
    begin
        case (ctrl.cond)
            COND_NO_INPUT:    cond_hit = !s_accept;
            COND_ZERO_ROUNDS: cond_hit = (rounds_reg == 8'd0);
            COND_MORE_ROUNDS: cond_hit = (cnt_reg != 8'd1);
            COND_OUT_BUSY:    cond_hit = out_busy;
            default:          cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? ctrl.target : step_t'(pc_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            rounds_reg    <= 8'd8;
            pc_reg        <= STEP_IDLE;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KEY_LOW:     key_low_reg  <= cfg_data;
                    REG_KEY_HIGH:    key_high_reg <= cfg_data;
                    REG_ROUND_COUNT: rounds_reg   <= cfg_data[7:0];
                    default:         ;
                endcase
            end

            pc_reg <= pc_next;

            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;

            if (ctrl.absorb)
                open_reg <= 1'b1;

            if (ctrl.finish && final_reg && !out_busy)
            begin
                out_valid_reg <= 1'b1;
                open_reg      <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            blk_reg   <= blk_next;
            final_reg <= s_tlast;
            full_reg  <= !s_tlast || (s_tuser >= BLOCK_BYTES);
        end
        if (ctrl.absorb)
        begin
            chain_reg <= (open_reg ? chain_reg : key) ^ blk_reg
                       ^ (final_reg ? lk : {BLOCK_W{1'b0}});
            cnt_reg   <= rounds_reg;
        end
        if (ctrl.arx)
        begin
            chain_reg <= arx_out;
            cnt_reg   <= cnt_reg - 8'd1;
        end
        if (ctrl.finish && final_reg && !out_busy)
            tag_reg <= chain_reg ^ lk;
    end

endmodule

>>> rtl/core/chaskey_chk.sv
module chaskey_chk
    import chaskey_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [BLOCK_W-1:0]   m_tdata
);

    // a stalled tag holds
    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("tag changed or dropped while stalled");

    // one block at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a block is in flight");

    // a tag only appears at the end of a block's work
    a_tag_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("tag raised without a finishing step");

    // no tag straight after the input transaction
    a_no_early_tag: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("tag raised too early");

endmodule

bind chaskey_mac_engine chaskey_chk u_chk (.*);
